@@ rtl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants for the semiprime classifier: microcode control
// word, datapath status flags, opcodes, jump conditions and verdict codes.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // default width of the classified value
    localparam int VALUE_WIDTH_DEF = 31;

    // microprogram counter width
    localparam int UPC_W = 5;

    // verdict codes
    localparam logic [1:0] VERDICT_PAIR   = 2'd0;
    localparam logic [1:0] VERDICT_SQUARE = 2'd1;
    localparam logic [1:0] VERDICT_OTHER  = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SHIFT,
        OP_DIV_START,
        OP_TAKE_Q,
        OP_NEXT_D,
        OP_NOTE_REM,
        OP_EMIT_FINAL,
        OP_EMIT_SQ,
        OP_EMIT_SMALL,
        OP_EMIT_MANY
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_LT6,
        C_ODD,
        C_CNT3,
        C_SQ_GT,
        C_DIV_BUSY,
        C_REM_NZ,
        C_REM_LE2
    } cond_t;

    // one microcode word
    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    // flags from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic lt6;
        logic odd;
        logic cnt3;
        logic sq_gt;
        logic div_busy;
        logic rem_nz;
        logic rem_le2;
    } status_t;

endpackage

@@ rtl/tsp_div.sv @@
// ----------------------------------------------------------------------------
// tsp_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder
// hold after completion until the next start.
// ----------------------------------------------------------------------------
module tsp_div
    import tsp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DIV_WIDTH   = VALUE_WIDTH_DEF / 2 + 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]   divisor,
    output logic                   busy,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic                   rem_nz
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] q_reg;
    logic [DIV_WIDTH-1:0]   r_reg;
    logic [DIV_WIDTH-1:0]   d_reg;

    logic [DIV_WIDTH:0]     shifted;
    logic [DIV_WIDTH:0]     diff;
    logic                   ge;
    logic [DIV_WIDTH-1:0]   r_next;
    logic [VALUE_WIDTH-1:0] q_next;

    // one restoring step
    always_comb
    begin
        shifted = {r_reg, q_reg[VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = ~diff[DIV_WIDTH];
        r_next  = ge ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
        q_next  = {q_reg[VALUE_WIDTH-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(VALUE_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
    assign rem_nz   = (r_reg != '0);

endmodule

@@ rtl/tsp_seq.sv @@
// ----------------------------------------------------------------------------
// tsp_seq
// Microcode sequencer: program counter, control store and conditional
// jump logic. Step zero is the idle step.
// ----------------------------------------------------------------------------
module tsp_seq
    import tsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl,
    output logic    idle
);

    // program labels
    localparam logic [UPC_W-1:0] L_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] L_TWO   = 5'd2;
    localparam logic [UPC_W-1:0] L_ODD   = 5'd6;
    localparam logic [UPC_W-1:0] L_TRY   = 5'd7;
    localparam logic [UPC_W-1:0] L_WAIT  = 5'd8;
    localparam logic [UPC_W-1:0] L_NEXTD = 5'd13;
    localparam logic [UPC_W-1:0] L_TAIL  = 5'd14;
    localparam logic [UPC_W-1:0] L_ESQ   = 5'd18;
    localparam logic [UPC_W-1:0] L_E1    = 5'd19;
    localparam logic [UPC_W-1:0] L_E2    = 5'd20;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    // control store
    always_comb
    begin
        unique case (upc_reg)
            5'd0:    ctrl = '{OP_LOAD,       C_NO_START, L_IDLE};
            5'd1:    ctrl = '{OP_NOP,        C_LT6,      L_E1};
            5'd2:    ctrl = '{OP_NOP,        C_ODD,      L_ODD};
            5'd3:    ctrl = '{OP_SHIFT,      C_NEVER,    L_IDLE};
            5'd4:    ctrl = '{OP_NOP,        C_CNT3,     L_E2};
            5'd5:    ctrl = '{OP_NOP,        C_ALWAYS,   L_TWO};
            5'd6:    ctrl = '{OP_NOP,        C_SQ_GT,    L_TAIL};
            5'd7:    ctrl = '{OP_DIV_START,  C_NEVER,    L_IDLE};
            5'd8:    ctrl = '{OP_NOP,        C_DIV_BUSY, L_WAIT};
            5'd9:    ctrl = '{OP_NOP,        C_REM_NZ,   L_NEXTD};
            5'd10:   ctrl = '{OP_TAKE_Q,     C_NEVER,    L_IDLE};
            5'd11:   ctrl = '{OP_NOP,        C_CNT3,     L_E2};
            5'd12:   ctrl = '{OP_NOP,        C_ALWAYS,   L_TRY};
            5'd13:   ctrl = '{OP_NEXT_D,     C_ALWAYS,   L_ODD};
            5'd14:   ctrl = '{OP_NOP,        C_REM_LE2,  L_ESQ};
            5'd15:   ctrl = '{OP_NOTE_REM,   C_NEVER,    L_IDLE};
            5'd16:   ctrl = '{OP_NOP,        C_CNT3,     L_E2};
            5'd17:   ctrl = '{OP_EMIT_FINAL, C_ALWAYS,   L_IDLE};
            5'd18:   ctrl = '{OP_EMIT_SQ,    C_ALWAYS,   L_IDLE};
            5'd19:   ctrl = '{OP_EMIT_SMALL, C_ALWAYS,   L_IDLE};
            5'd20:   ctrl = '{OP_EMIT_MANY,  C_ALWAYS,   L_IDLE};
            default: ctrl = '{OP_NOP,        C_ALWAYS,   L_IDLE};
        endcase
    end

    // jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = ~status.start;
            C_LT6:      take = status.lt6;
            C_ODD:      take = status.odd;
            C_CNT3:     take = status.cnt3;
            C_SQ_GT:    take = status.sq_gt;
            C_DIV_BUSY: take = status.div_busy;
            C_REM_NZ:   take = status.rem_nz;
            C_REM_LE2:  take = status.rem_le2;
            default:    take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= L_IDLE;
        else
            upc_reg <= upc_next;
    end

    assign idle = (upc_reg == L_IDLE);

endmodule

@@ rtl/semiprime_classifier.sv @@
// Values below six are decided without trial division; otherwise each factor of two
// and each odd trial divisor adds to the run time, every trial division running on
// the bit-serial divider.
// Throughput: one value at a time; start is taken while busy is low, which can be
// the same cycle the previous verdict is strobed. Results cannot be stalled.
// Reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
// semiprime_classifier
// Trial-division classifier: a microcoded sequencer drives a datapath of
// cofactor, trial divisor, running square, factor count and a serial divider.
// ----------------------------------------------------------------------------
module semiprime_classifier
    import tsp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] number,
    output logic                   done,
    output logic [1:0]             verdict
);

    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW = VALUE_WIDTH + 2;

    ctrl_t   ctrl;
    status_t status;
    logic    idle;

    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [DW-1:0]          div_reg;
    logic [SW-1:0]          sq_reg;
    logic [1:0]             cnt_reg;
    logic [VALUE_WIDTH-1:0] first_reg;
    logic                   done_reg;
    logic [1:0]             verdict_reg;

    logic                   div_start;
    logic                   div_busy;
    logic [VALUE_WIDTH-1:0] quotient;
    logic                   rem_nz;

    logic                   note;
    logic [VALUE_WIDTH-1:0] note_val;
    logic [1:0]             cnt_inc;

    tsp_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .idle   (idle)
    );

    tsp_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (div_reg),
        .busy     (div_busy),
        .quotient (quotient),
        .rem_nz   (rem_nz)
    );

    assign div_start = (ctrl.op == OP_DIV_START);

    // status flags for the sequencer
    always_comb
    begin
        status.start    = start;
        status.lt6      = (rem_reg < VALUE_WIDTH'(6));
        status.odd      = rem_reg[0];
        status.cnt3     = (cnt_reg == 2'd3);
        status.sq_gt    = (sq_reg > SW'(rem_reg));
        status.div_busy = div_busy;
        status.rem_nz   = rem_nz;
        status.rem_le2  = (rem_reg <= VALUE_WIDTH'(2));
    end

    // prime factor bookkeeping
    always_comb
    begin
        note     = 1'b0;
        note_val = VALUE_WIDTH'(2);
        case (ctrl.op)
            OP_SHIFT:
            begin
                note     = 1'b1;
                note_val = VALUE_WIDTH'(2);
            end
            OP_TAKE_Q:
            begin
                note     = 1'b1;
                note_val = VALUE_WIDTH'(div_reg);
            end
            OP_NOTE_REM:
            begin
                note     = 1'b1;
                note_val = rem_reg;
            end
            default:
            begin
                note     = 1'b0;
                note_val = VALUE_WIDTH'(2);
            end
        endcase
        cnt_inc = (cnt_reg == 2'd3) ? 2'd3 : cnt_reg + 2'd1;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (note)
        begin
            if (cnt_reg == 2'd0)
                first_reg <= note_val;
        end
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    rem_reg   <= number;
                    div_reg   <= DW'(3);
                    sq_reg    <= SW'(9);
                    first_reg <= '0;
                end
            end
            OP_SHIFT:  rem_reg <= {1'b0, rem_reg[VALUE_WIDTH-1:1]};
            OP_TAKE_Q: rem_reg <= quotient;
            OP_NEXT_D:
            begin
                div_reg <= div_reg + DW'(2);
                sq_reg  <= sq_reg + SW'({div_reg, 2'b00}) + SW'(4);
            end
            default:
            begin
            end
        endcase
    end

    // factor count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 2'd0;
            done_reg    <= 1'b0;
            verdict_reg <= VERDICT_SQUARE;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.op == OP_LOAD && start)
                cnt_reg <= 2'd0;
            else if (note)
                cnt_reg <= cnt_inc;
            unique case (ctrl.op)
                OP_EMIT_FINAL:
                begin
                    done_reg <= 1'b1;
                    if (cnt_reg == 2'd2)
                        verdict_reg <= (first_reg != rem_reg) ? VERDICT_PAIR
                                                             : VERDICT_SQUARE;
                    else
                        verdict_reg <= VERDICT_OTHER;
                end
                OP_EMIT_SQ:
                begin
                    done_reg    <= 1'b1;
                    verdict_reg <= (cnt_reg == 2'd2) ? VERDICT_SQUARE : VERDICT_OTHER;
                end
                OP_EMIT_SMALL:
                begin
                    done_reg    <= 1'b1;
                    verdict_reg <= VERDICT_SQUARE;
                end
                OP_EMIT_MANY:
                begin
                    done_reg    <= 1'b1;
                    verdict_reg <= VERDICT_OTHER;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy    = ~idle;
    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule
